### src/bei_pkg.sv
package bei_pkg;

   // table depth and derived widths
   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // field widths
   localparam int CMD_W   = 2;
   localparam int TIME_W  = 14;
   localparam int LEVEL_W = 16;
   localparam int COUNT_W = 5;

   // level difference times time offset, signed
   localparam int DIFF_W = LEVEL_W + 1;
   localparam int PROD_W = DIFF_W + TIME_W + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_EVAL   = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

endpackage

### src/bei_divider.sv
module bei_divider
   import bei_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [PROD_W-1:0] dividend,
   input  logic [TIME_W-1:0]        divisor,
   output logic                     done,
   output logic signed [PROD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(PROD_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic              neg_ff;
   logic [PROD_W-1:0] quo_ff;
   logic [TIME_W-1:0] rem_ff;

   logic [TIME_W:0]   shifted;
   logic              fits;
   logic [TIME_W-1:0] rem_in;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[PROD_W-1]};
      fits    = (shifted >= {1'b0, divisor});
      rem_in  = fits ? (shifted[TIME_W-1:0] - divisor) : shifted[TIME_W-1:0];
   end

   // sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && !start && (step_ff == LAST_STEP);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // work on magnitudes, restore the sign at the end
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[PROD_W-1];
         quo_ff <= dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[PROD_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

### src/breakpoint_envelope_interpolator_core.sv
// Breakpoint envelope interpolator. Clear and append requests fill a table of
// up to MAX_POINTS (time, level) breakpoints; after acceptance the sequencer
// goes to its response state, which loads the response register and then
// returns to idle for the next request. An append to a full table is dropped
// and flagged. An evaluate request scans the table one entry at a time from a
// registered-read memory, through a fetch and a check state per entry visited.
// When the query falls inside a span of positive length it then passes through
// a multiply state, a state that starts the 32-step restoring divider and a
// state that waits on it, before the response state. The block takes no
// request while it works on one; a finished response sits in the output
// register and does not hold up the next request, but the response after it
// waits in the sequencer until the output is taken.
module breakpoint_envelope_interpolator_core
   import bei_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_W-1:0]          req_command,
   input  logic [TIME_W-1:0]         req_time_value,
   input  logic signed [LEVEL_W-1:0] req_level_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [LEVEL_W-1:0] rsp_level_out,
   output logic                      rsp_table_full,
   output logic [COUNT_W-1:0]        rsp_point_count
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_RESP
   } state_type;

   state_type state_ff;

   // breakpoint store
   logic [TIME_W-1:0]         time_mem  [MAX_POINTS];
   logic signed [LEVEL_W-1:0] level_mem [MAX_POINTS];
   logic [TIME_W-1:0]         rd_time_ff;
   logic signed [LEVEL_W-1:0] rd_level_ff;

   logic [CNT_W-1:0]          count_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [TIME_W-1:0]         query_ff;
   logic [TIME_W-1:0]         prev_time_ff;
   logic signed [LEVEL_W-1:0] prev_level_ff;
   logic signed [DIFF_W-1:0]  dl_ff;
   logic [TIME_W-1:0]         dt_ff;
   logic [TIME_W-1:0]         span_ff;
   logic signed [PROD_W-1:0]  prod_ff;

   logic signed [LEVEL_W-1:0] res_level_ff;
   logic                      res_full_ff;

   logic                      rsp_valid_ff;
   logic signed [LEVEL_W-1:0] rsp_level_ff;
   logic                      rsp_full_ff;
   logic [CNT_W-1:0]          rsp_count_ff;

   logic                      req_accept;
   logic                      out_free;
   logic                      append_ok;
   logic                      last_entry;
   logic                      div_start;
   logic                      div_done;
   logic signed [PROD_W-1:0]  div_quotient;
   command_type               req_cmd;

   assign req_cmd    = command_type'(req_command);
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign append_ok  = (count_ff < CNT_W'(MAX_POINTS));
   assign last_entry = ({1'b0, idx_ff} + 1'b1) == count_ff;
   assign div_start  = (state_ff == ST_DIV_START);

   // write on append, registered read of the scanned entry
   always_ff @(posedge clock) begin
      if (req_accept && req_cmd == CMD_APPEND && append_ok) begin
         time_mem[count_ff[IDX_W-1:0]]  <= req_time_value;
         level_mem[count_ff[IDX_W-1:0]] <= req_level_value;
      end
      rd_time_ff  <= time_mem[idx_ff];
      rd_level_ff <= level_mem[idx_ff];
   end

   // divider for the interpolation quotient
   bei_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the response once taken, unless a new one replaces it
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  res_level_ff <= '0;
                  res_full_ff  <= (req_cmd == CMD_APPEND) && !append_ok;
                  query_ff     <= req_time_value;
                  idx_ff       <= '0;
                  if (req_cmd == CMD_EVAL && count_ff != '0) begin
                     state_ff <= ST_FETCH;
                  end else begin
                     state_ff <= ST_RESP;
                  end
                  unique case (req_cmd)
                     CMD_CLEAR: count_ff <= '0;
                     CMD_APPEND: begin
                        if (append_ok) begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     CMD_EVAL: ;
                     CMD_NONE: ;
                  endcase
               end
            end
            ST_FETCH: state_ff <= ST_CHECK;
            ST_CHECK: begin
               if (query_ff <= rd_time_ff) begin
                  if (idx_ff == '0 || rd_time_ff <= prev_time_ff) begin
                     res_level_ff <= rd_level_ff;
                     state_ff     <= ST_RESP;
                  end else begin
                     dl_ff    <= DIFF_W'(rd_level_ff) - DIFF_W'(prev_level_ff);
                     dt_ff    <= query_ff - prev_time_ff;
                     span_ff  <= rd_time_ff - prev_time_ff;
                     state_ff <= ST_MUL;
                  end
               end else begin
                  // past this entry: advance, or end on the last level
                  prev_time_ff  <= rd_time_ff;
                  prev_level_ff <= rd_level_ff;
                  if (last_entry) begin
                     res_level_ff <= rd_level_ff;
                     state_ff     <= ST_RESP;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= ST_FETCH;
                  end
               end
            end
            ST_MUL: begin
               prod_ff  <= dl_ff * $signed({1'b0, dt_ff});
               state_ff <= ST_DIV_START;
            end
            ST_DIV_START: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_done) begin
                  res_level_ff <= prev_level_ff + div_quotient[LEVEL_W-1:0];
                  state_ff     <= ST_RESP;
               end
            end
            ST_RESP: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_level_ff <= res_level_ff;
                  rsp_full_ff  <= res_full_ff;
                  rsp_count_ff <= count_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level_out   = rsp_level_ff;
   assign rsp_table_full  = rsp_full_ff;
   assign rsp_point_count = COUNT_W'(rsp_count_ff);

   // a dropped append only happens with the table full
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_point_count == COUNT_W'(MAX_POINTS))
      else $error("table_full with table not full");

   // the held count never exceeds the table depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("breakpoint count beyond table depth");

   // the divider only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   // a response is loaded only from the response state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_RESP)
      else $error("response raised outside the response state");

endmodule

### sim/breakpoint_envelope_interpolator_core_tb.sv
module breakpoint_envelope_interpolator_core_tb
   import bei_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned       IDLE_LIMIT   = 2000;
   localparam int unsigned       DRAIN_CYCLES = 100;
   localparam logic [TIME_W-1:0] TIME_MAX     = '1;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] level;
      logic                      dropped;
      logic [COUNT_W-1:0]        count;
   } envelope_result_type;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic                      req_stall;
   logic [CMD_W-1:0]          req_command     = CMD_NONE;
   logic [TIME_W-1:0]         req_time_value  = '0;
   logic signed [LEVEL_W-1:0] req_level_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall       = 1'b0;
   logic signed [LEVEL_W-1:0] rsp_level_out;
   logic                      rsp_table_full;
   logic [COUNT_W-1:0]        rsp_point_count;

   // predicted breakpoint table
   logic [TIME_W-1:0]         held_time  [MAX_POINTS];
   logic signed [LEVEL_W-1:0] held_level [MAX_POINTS];
   int unsigned               held_points = 0;

   envelope_result_type awaited_results[$];

   bit          steady_stream    = 1'b0;
   int unsigned cycle_count      = 0;
   int unsigned stall_left       = 0;
   int unsigned idle_cycles      = 0;
   int unsigned requests_sent    = 0;
   int unsigned evaluations      = 0;
   int unsigned appends          = 0;
   int unsigned appends_refused  = 0;
   int unsigned clears           = 0;
   int unsigned unused_codes     = 0;
   int unsigned responses_seen   = 0;
   int unsigned mismatches       = 0;

   breakpoint_envelope_interpolator_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_time_value  (req_time_value),
      .req_level_value (req_level_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_level_out   (rsp_level_out),
      .rsp_table_full  (rsp_table_full),
      .rsp_point_count (rsp_point_count)
   );

   always #4 clock = ~clock;

   // piecewise linear level over the held points, quotient truncated toward zero
   function automatic logic signed [LEVEL_W-1:0] level_at(logic [TIME_W-1:0] query);
      longint t0, t1, l0, l1, span, point;
      if (held_points == 0) return '0;
      if (query <= held_time[0]) return held_level[0];
      for (int k = 1; k < held_points; k++) begin
         if (query <= held_time[k]) begin
            t0   = held_time[k-1];
            t1   = held_time[k];
            l0   = held_level[k-1];
            l1   = held_level[k];
            span = t1 - t0;
            if (span <= 0) return held_level[k];
            point = l0 + ((l1 - l0) * (longint'(query) - t0)) / span;
            return point[LEVEL_W-1:0];
         end
      end
      return held_level[held_points-1];
   endfunction

   // advance the predicted table by one request and return its response
   function automatic envelope_result_type apply_envelope_request(
      command_type cmd, logic [TIME_W-1:0] query, logic signed [LEVEL_W-1:0] lvl);
      envelope_result_type r;
      r = '0;
      case (cmd)
         CMD_CLEAR: begin
            held_points = 0;
         end
         CMD_APPEND: begin
            if (held_points < MAX_POINTS) begin
               held_time[held_points]  = query;
               held_level[held_points] = lvl;
               held_points++;
            end else begin
               r.dropped = 1'b1;
            end
         end
         CMD_EVAL: begin
            r.level = level_at(query);
         end
         default: ;
      endcase
      r.count = COUNT_W'(held_points);
      return r;
   endfunction

   // predict on every accepted request
   always @(posedge clock) begin : accept_request
      envelope_result_type fresh;
      if (!reset && req_valid && !req_stall) begin
         fresh = apply_envelope_request(command_type'(req_command), req_time_value,
                                        req_level_value);
         awaited_results = {awaited_results, fresh};
         case (command_type'(req_command))
            CMD_CLEAR:  clears++;
            CMD_APPEND: begin
               appends++;
               if (fresh.dropped) appends_refused++;
            end
            CMD_EVAL:   evaluations++;
            default:    unused_codes++;
         endcase
      end
   end

   task automatic report_mismatch(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
   endtask

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin : check_response
      envelope_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (awaited_results.size() == 0) begin
            $display("%0t: response with nothing outstanding, level %0d count %0d",
                     $time, rsp_level_out, rsp_point_count);
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_level_out !== want.level)
               report_mismatch("level_out", want.level, rsp_level_out);
            if (rsp_table_full !== want.dropped)
               report_mismatch("table_full", want.dropped, rsp_table_full);
            if (rsp_point_count !== want.count)
               report_mismatch("point_count", want.count, rsp_point_count);
         end
      end
   end

   // response stalls in bursts, with quiet stretches in between
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || steady_stream || ((cycle_count + 1000) % 2500) >= 1700) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 6) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("FAIL breakpoint_envelope_interpolator_core");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // present one request, with an optional gap first, and hold it until taken
   task automatic send_request(command_type cmd, logic [TIME_W-1:0] query,
                               logic signed [LEVEL_W-1:0] lvl);
      if (!steady_stream && (cycle_count % 3000) < 2000 && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_time_value  <= query;
      req_level_value <= lvl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (cmd != CMD_NONE) requests_sent++;
   endtask

   function automatic logic signed [LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         default: return LEVEL_W'($urandom);
      endcase
   endfunction

   // clear, append non-decreasing times with random levels, then query the envelope
   task automatic send_envelope(int unsigned points, int unsigned queries);
      int stamp, first_stamp, stride;
      send_request(CMD_CLEAR, TIME_W'($urandom), LEVEL_W'($urandom));
      stamp       = $urandom_range(0, 3000);
      first_stamp = stamp;
      stride      = 26000 / (points + 1);
      for (int i = 0; i < points; i++) begin
         send_request(CMD_APPEND, TIME_W'(stamp), pick_level());
         if (i + 1 < points) stamp = stamp + $urandom_range(0, stride);
         if (stamp > int'(TIME_MAX)) stamp = int'(TIME_MAX);
      end
      for (int j = 0; j < queries; j++) begin
         if ($urandom_range(0, 3) == 0)
            send_request(CMD_EVAL, TIME_W'($urandom_range(0, TIME_MAX)),
                         LEVEL_W'($urandom));
         else
            send_request(CMD_EVAL, TIME_W'($urandom_range(first_stamp, stamp)),
                         LEVEL_W'($urandom));
      end
   endtask

   task automatic test_empty_and_unused();
      send_request(CMD_CLEAR, '0, '0);
      send_request(CMD_EVAL, TIME_MAX, 16'sh7fff);
      send_request(CMD_NONE, TIME_MAX, -16'sd1);
   endtask

   // full-range span between both level extremes, queried in the middle and at the start
   task automatic test_extreme_span();
      send_request(CMD_APPEND, '0, 16'sh8000);
      send_request(CMD_APPEND, TIME_MAX, 16'sh7fff);
      send_request(CMD_EVAL, 14'd8191, '0);
      send_request(CMD_EVAL, '0, '0);
   endtask

   // times out of order: scan falls through to the last level
   task automatic test_unsorted_points();
      send_request(CMD_CLEAR, TIME_MAX, -16'sd1);
      send_request(CMD_APPEND, 14'd9000, 16'sd100);
      send_request(CMD_APPEND, 14'd2000, -16'sd500);
      send_request(CMD_EVAL, 14'd12000, '0);
   endtask

   // fill the table, then push one more and query above the nominal range
   task automatic test_full_table();
      for (int i = 0; i < MAX_POINTS - 2; i++)
         send_request(CMD_APPEND, TIME_W'(600 * i + 300), pick_level());
      send_request(CMD_APPEND, 14'd5000, 16'sd1234);
      send_request(CMD_EVAL, 14'd10001, '0);
   endtask

   task automatic test_random_envelopes(int unsigned target);
      while (requests_sent < target) begin
         if ($urandom_range(0, 4) != 0) begin
            send_envelope($urandom_range(0, MAX_POINTS + 2), $urandom_range(1, 6));
         end else begin
            repeat ($urandom_range(1, 6))
               send_request(command_type'($urandom_range(0, 3)), TIME_W'($urandom),
                            LEVEL_W'($urandom));
         end
      end
   endtask

   task automatic test_steady_stream(int unsigned target);
      steady_stream = 1'b1;
      test_random_envelopes(target);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_unused();
      test_extreme_span();
      test_unsorted_points();
      test_full_table();
      test_random_envelopes(900);
      test_steady_stream(1050);

      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d evaluations, %0d appends (%0d refused when full),",
               requests_sent + unused_codes, evaluations, appends, appends_refused);
      $display("%0d clears, %0d unused codes; checked %0d responses, %0d mismatches",
               clears, unused_codes, responses_seen, mismatches);
      if (mismatches == 0 && awaited_results.size() == 0)
         $display("PASS breakpoint_envelope_interpolator_core");
      else
         $display("FAIL breakpoint_envelope_interpolator_core");
      $finish;
   end

endmodule
